### rtl/core/cmsi_pkg.sv
// Shared types and constants of the colormap stop interpolator.
package cmsi_pkg;

    localparam int unsigned MaxStops   = 8;
    localparam int unsigned IdxW       = 3;
    localparam int unsigned CountW     = 4;
    localparam int unsigned PosW       = 16;
    localparam int unsigned ChanW      = 8;
    localparam int unsigned SampW      = 17;
    localparam int unsigned OneQ15     = 32768;
    localparam int unsigned ChanMax    = 255;
    localparam int unsigned DefHalf    = 163840;
    localparam int unsigned RecipFive  = 13108;
    localparam int unsigned RemW       = 23;
    localparam int unsigned DefW       = 20;
    localparam int unsigned DivSteps   = 8;
    localparam int unsigned NumStages  = 2 + DivSteps;

    // APB register indexes
    localparam logic REG_DISCRETE = 1'b0;
    localparam logic REG_COUNT    = 1'b1;

    // Input word kinds
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef enum logic [1:0] {
        SRC_LOW     = 2'd0,
        SRC_HIGH    = 2'd1,
        SRC_STOPS   = 2'd2,
        SRC_DEFAULT = 2'd3
    } src_t;

    typedef enum logic [1:0] {
        KIND_DIRECT  = 2'd0,
        KIND_LERP    = 2'd1,
        KIND_DEFAULT = 2'd2
    } kind_t;

    typedef logic [ChanW-1:0] chan_t;
    typedef chan_t [2:0] rgb_t;

    typedef struct packed {
        logic [PosW-1:0] pos;
        rgb_t            col;
    } stop_t;

    typedef struct packed {
        src_t                      src;
        kind_t                     kind;
        rgb_t                      col;
        rgb_t                      col_b;
        logic [PosW-1:0]           delta;
        logic [PosW-1:0]           den;
        logic [2:0][RemW-1:0]      rem;
        rgb_t                      quo;
        logic [2:0][DefW-1:0]      dnum;
    } stage_t;

endpackage

### rtl/core/colormap_stop_interpolator_top.sv
// Colormap stop interpolator: stop table, lookup pipeline and APB registers.
//
//  channel | dir | handshake            | content
//  s_*     | in  | s_tvalid / s_tready  | write or lookup word, opcode in s_tuser
//  m_*     | out | m_tvalid / m_tready  | color word, color source in m_tuser
//  apb     | in  | psel/penable/pready  | discrete_mode at 0x0, stop_count at 0x4
//
// One word enters per cycle while the output is not stalled; a lookup result passes through
// twelve registers: input register, classify, multiply, eight divider steps, output
// register. Most of them are the steps of the bit-per-stage divider.
// Writes update the stop table at the edge they are taken and produce no result.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
// Reset clears the valid bits and the configuration registers; the stop table holds garbage until written.
module colormap_stop_interpolator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] stop_index, [18:3] stop_position, [26:19] stop_red, [34:27] stop_green,
    // [42:35] stop_blue, [59:43] sample, [63:60] zero
    input  logic [63:0] s_tdata,
    // [0] opcode
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [23:0] m_tdata,
    // [1:0] color_source
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NS = cmsi_pkg::NumStages;

    logic                               discrete_reg;
    logic [cmsi_pkg::CountW-1:0]        count_reg;
    cmsi_pkg::stop_t                    table_mem [cmsi_pkg::MaxStops];

    logic                               in_valid_reg;
    logic [cmsi_pkg::SampW-1:0]         in_sample_reg;

    logic [NS-1:0]                      stg_valid_reg;
    cmsi_pkg::stage_t                   stg_reg  [NS];
    cmsi_pkg::stage_t                   a_next;
    cmsi_pkg::stage_t                   b_next;
    cmsi_pkg::stage_t                   stg_next [2:NS-1];

    logic                               out_valid_reg;
    logic [23:0]                        out_data_reg;
    logic [23:0]                        out_data_next;
    logic [1:0]                         out_src_reg;

    logic                               adv;
    logic                               s_accept;
    logic                               cfg_write;
    logic [cmsi_pkg::PosW-1:0]          wr_pos;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign s_accept  = s_tvalid && adv;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_src_reg;

    // Register reads
    always_comb
    begin
        case (paddr[2])
            cmsi_pkg::REG_DISCRETE: prdata = {31'd0, discrete_reg};
            cmsi_pkg::REG_COUNT:    prdata = {28'd0, count_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discrete_reg <= 1'b0;
            count_reg    <= 4'd2;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                cmsi_pkg::REG_DISCRETE: discrete_reg <= pwdata[0];
                cmsi_pkg::REG_COUNT:    count_reg    <= pwdata[3:0];
                default:                discrete_reg <= discrete_reg;
            endcase
        end
    end

    // Saturate written position to one
    assign wr_pos = (s_tdata[18:3] > 16'(cmsi_pkg::OneQ15)) ?
                    16'(cmsi_pkg::OneQ15) : s_tdata[18:3];

    // Store a stop on a write word
    always_ff @(posedge clk)
    begin
        if (s_accept && s_tuser[0] == cmsi_pkg::OP_WRITE)
        begin
            table_mem[s_tdata[2:0]] <= '{pos: wr_pos,
                                         col: {s_tdata[42:35], s_tdata[34:27],
                                               s_tdata[26:19]}};
        end
    end

    // Input register: only lookups travel down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= s_tvalid && s_tuser[0] == cmsi_pkg::OP_LOOKUP;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            in_sample_reg <= s_tdata[59:43];
    end

    // Stage A: clamp, search the stops in parallel, fetch the bracketing pair
    always_comb
    begin : stage_a
        logic [cmsi_pkg::CountW-1:0] n;
        logic [cmsi_pkg::PosW-1:0]   v;
        logic [cmsi_pkg::PosW-1:0]   up;
        logic [cmsi_pkg::MaxStops-1:0] hit;
        logic [cmsi_pkg::IdxW-1:0]   sel;
        logic [cmsi_pkg::IdxW-1:0]   last;
        logic                        found;
        cmsi_pkg::stop_t             lo_e;
        cmsi_pkg::stop_t             hi_e;
        n = count_reg;
        if (n < 4'd2)
            n = 4'd2;
        if (n > 4'(cmsi_pkg::MaxStops))
            n = 4'(cmsi_pkg::MaxStops);
        last = 3'(n - 4'd1);
        v    = in_sample_reg[15:0];
        hit  = '0;
        for (int i = 0; i < cmsi_pkg::MaxStops; i++)
        begin
            up = 16'(cmsi_pkg::OneQ15);
            if (i < cmsi_pkg::MaxStops - 1)
            begin
                if (4'(i + 1) < n)
                    up = table_mem[i + 1].pos;
                if (discrete_reg)
                    hit[i] = (4'(i) < n) && table_mem[i].pos <= v && v < up;
                else
                    hit[i] = (4'(i + 1) < n) && table_mem[i].pos <= v && v <= up;
            end
            else if (discrete_reg)
            begin
                hit[i] = (4'(i) < n) && table_mem[i].pos <= v && v < up;
            end
        end
        sel   = '0;
        found = 1'b0;
        for (int i = cmsi_pkg::MaxStops - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                sel   = 3'(i);
                found = 1'b1;
            end
        end
        lo_e = table_mem[sel];
        hi_e = table_mem[3'(sel + 3'd1)];

        a_next       = '0;
        a_next.src   = cmsi_pkg::SRC_STOPS;
        a_next.kind  = cmsi_pkg::KIND_DIRECT;
        a_next.col   = lo_e.col;
        a_next.col_b = hi_e.col;
        a_next.den   = 16'(hi_e.pos - lo_e.pos);
        a_next.delta = 16'(v - lo_e.pos);
        if (in_sample_reg[16])
        begin
            a_next.src = cmsi_pkg::SRC_LOW;
            a_next.col = table_mem[0].col;
        end
        else if ($signed(in_sample_reg) > $signed(17'(cmsi_pkg::OneQ15)))
        begin
            a_next.src = cmsi_pkg::SRC_HIGH;
            a_next.col = table_mem[last].col;
        end
        else if (!found)
        begin
            a_next.src   = cmsi_pkg::SRC_DEFAULT;
            a_next.kind  = cmsi_pkg::KIND_DEFAULT;
            a_next.delta = v;
        end
        else if (!discrete_reg && a_next.den != '0)
        begin
            a_next.kind = cmsi_pkg::KIND_LERP;
        end
    end

    // Stage B: weighted sums for interpolation, raw sums for the default map
    always_comb
    begin : stage_b
        logic [cmsi_pkg::PosW-1:0] w_lo;
        logic [23:0]               acc;
        logic [cmsi_pkg::PosW-1:0] v;
        logic [cmsi_pkg::PosW-1:0] t;
        logic [cmsi_pkg::DefW-1:0] base;
        logic [cmsi_pkg::DefW-1:0] dr;
        logic [cmsi_pkg::DefW-1:0] dg;
        logic [cmsi_pkg::DefW-1:0] db;
        b_next = stg_reg[0];
        w_lo = 16'(stg_reg[0].den - stg_reg[0].delta);
        for (int c = 0; c < 3; c++)
        begin
            acc = 24'(stg_reg[0].col[c] * w_lo) + 24'(stg_reg[0].col_b[c] * stg_reg[0].delta)
                  + 24'(stg_reg[0].den >> 1);
            b_next.rem[c] = acc[cmsi_pkg::RemW-1:0];
        end
        // Grey base fades out over the first quarter
        v    = stg_reg[0].delta;
        base = (v >= 16'd8192) ? '0 : 20'(9 * (cmsi_pkg::OneQ15 - 32'(v) * 4));
        dr   = base;
        dg   = base;
        db   = base;
        t    = '0;
        if (v < 16'd8192)
        begin
            db = 20'(base + 40 * 32'(v));
        end
        else if (v < 16'd16384)
        begin
            t  = 16'((v - 16'd8192) << 2);
            db = 20'(base + 10 * (cmsi_pkg::OneQ15 - 32'(t)));
            dg = 20'(base + 10 * 32'(t));
        end
        else if (v < 16'd24576)
        begin
            t  = 16'((v - 16'd16384) << 2);
            dg = 20'(base + 10 * (cmsi_pkg::OneQ15 - 32'(t)));
            dr = 20'(base + 10 * 32'(t));
        end
        else if (v < 16'(cmsi_pkg::OneQ15))
        begin
            dr = 20'(base + 10 * cmsi_pkg::OneQ15);
            dg = 20'(base + 40 * (32'(v) - 32'd24576));
        end
        b_next.dnum[0] = dr;
        b_next.dnum[1] = dg;
        b_next.dnum[2] = db;
    end

    // Divider steps: one quotient bit per stage; default map scaling rides along
    always_comb
    begin : div_steps
        logic [cmsi_pkg::RemW-1:0] trial;
        logic [27:0]               y;
        logic [26:0]               p;
        for (int j = 2; j < NS; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            trial = cmsi_pkg::RemW'(stg_reg[j-1].den) << (NS - 1 - j);
            for (int c = 0; c < 3; c++)
            begin
                if (stg_reg[j-1].rem[c] >= trial)
                begin
                    stg_next[j].rem[c]             = stg_reg[j-1].rem[c] - trial;
                    stg_next[j].quo[c][NS - 1 - j] = 1'b1;
                end
                // Scale by channel max over 327680: shift by 16, then divide by five
                if (j == 2)
                begin
                    y = 28'(stg_reg[j-1].dnum[c] * cmsi_pkg::ChanMax) + 28'(cmsi_pkg::DefHalf);
                    stg_next[j].dnum[c] = 20'(y[27:16]);
                end
                if (j == 3)
                begin
                    p = 27'(stg_reg[j-1].dnum[c][11:0] * cmsi_pkg::RecipFive);
                    stg_next[j].col[c] = (p[26:16] > 11'(cmsi_pkg::ChanMax)) ?
                                         8'(cmsi_pkg::ChanMax) : p[23:16];
                    if (stg_reg[j-1].kind != cmsi_pkg::KIND_DEFAULT)
                        stg_next[j].col[c] = stg_reg[j-1].col[c];
                end
            end
        end
    end

    // Advance the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= '0;
        else if (adv)
            stg_valid_reg <= {stg_valid_reg[NS-2:0], in_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[0] <= a_next;
            stg_reg[1] <= b_next;
            for (int j = 2; j < NS; j++)
                stg_reg[j] <= stg_next[j];
        end
    end

    // Pick the color for the output word
    always_comb
    begin
        case (stg_reg[NS-1].kind)
            cmsi_pkg::KIND_LERP: out_data_next = stg_reg[NS-1].quo;
            default:             out_data_next = stg_reg[NS-1].col;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= stg_valid_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_src_reg  <= stg_reg[NS-1].src;
        end
    end

endmodule

### rtl/core/cmsi_checker.sv
// Port checker of the colormap stop interpolator and its bind.
module cmsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic [31:0] prdata,
    input logic        pready
);

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // Drop input ready only under an output stall
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // Keep unused register bits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:4] == 28'd0)
        else $error("register read has stray upper bits");

    // Never wait on the register port
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind colormap_stop_interpolator_top cmsi_checker u_cmsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .prdata   (prdata),
    .pready   (pready)
);

### tb/tb_colormap_stop_interpolator_top.sv
// Self-checking testbench for the colormap stop interpolator top level.
module tb_colormap_stop_interpolator_top;

    typedef struct {
        cmsi_pkg::chan_t red;
        cmsi_pkg::chan_t green;
        cmsi_pkg::chan_t blue;
        cmsi_pkg::src_t  src;
    } color_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the table and the registers
    logic [cmsi_pkg::PosW-1:0] stop_pos [cmsi_pkg::MaxStops];
    cmsi_pkg::chan_t           stop_col [cmsi_pkg::MaxStops][3];
    logic                      mode_banded;
    logic [3:0]                count_raw;

    color_t color_queue [$];
    int     mismatches = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     hold_cycles = 0;
    int     lookups_sent = 0;
    int     writes_sent = 0;
    int     colors_seen = 0;

    colormap_stop_interpolator_top uut (.*);

    always #6 clk = ~clk;

    function automatic cmsi_pkg::chan_t lerp_channel(cmsi_pkg::chan_t a, cmsi_pkg::chan_t b,
                                                     int unsigned d, int unsigned span);
        longint unsigned num;
        num = longint'(a) * (span - d) + longint'(b) * d;
        return cmsi_pkg::chan_t'((num + span / 2) / span);
    endfunction

    function automatic cmsi_pkg::chan_t scale_default(longint unsigned num);
        longint unsigned v;
        v = (num * cmsi_pkg::ChanMax + 163840) / 327680;
        if (v > cmsi_pkg::ChanMax) v = cmsi_pkg::ChanMax;
        return cmsi_pkg::chan_t'(v);
    endfunction

    function automatic color_t stop_color(int i, cmsi_pkg::src_t src);
        color_t c;
        c.red = stop_col[i][0];
        c.green = stop_col[i][1];
        c.blue = stop_col[i][2];
        c.src = src;
        return c;
    endfunction

    function automatic color_t predict_color(logic [cmsi_pkg::SampW-1:0] raw);
        int              n;
        int              s;
        int unsigned     up;
        int unsigned     span;
        int unsigned     d;
        longint unsigned m;
        longint unsigned t;
        longint unsigned rr;
        longint unsigned gg;
        longint unsigned bb;
        color_t          c;
        n = count_raw;
        if (n < 2) n = 2;
        if (n > cmsi_pkg::MaxStops) n = cmsi_pkg::MaxStops;
        s = $signed(raw);
        if (s < 0) return stop_color(0, cmsi_pkg::SRC_LOW);
        if (s > cmsi_pkg::OneQ15) return stop_color(n - 1, cmsi_pkg::SRC_HIGH);
        if (mode_banded)
        begin
            for (int i = 0; i < n; i++)
            begin
                up = (i + 1 < n) ? stop_pos[i + 1] : cmsi_pkg::OneQ15;
                if (stop_pos[i] <= s && s < up) return stop_color(i, cmsi_pkg::SRC_STOPS);
            end
        end
        else
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                if (stop_pos[i] <= s && s <= stop_pos[i + 1])
                begin
                    span = stop_pos[i + 1] - stop_pos[i];
                    d = s - stop_pos[i];
                    if (span == 0) return stop_color(i, cmsi_pkg::SRC_STOPS);
                    c.red = lerp_channel(stop_col[i][0], stop_col[i + 1][0], d, span);
                    c.green = lerp_channel(stop_col[i][1], stop_col[i + 1][1], d, span);
                    c.blue = lerp_channel(stop_col[i][2], stop_col[i + 1][2], d, span);
                    c.src = cmsi_pkg::SRC_STOPS;
                    return c;
                end
            end
        end
        // fall back to the four-segment default map on a grey base
        m = 4 * s;
        if (m > cmsi_pkg::OneQ15) m = cmsi_pkg::OneQ15;
        rr = 9 * (cmsi_pkg::OneQ15 - m);
        gg = rr;
        bb = rr;
        if (s < 8192)
        begin
            bb += 40 * s;
        end
        else if (s < 16384)
        begin
            t = 4 * (s - 8192);
            bb += 10 * (cmsi_pkg::OneQ15 - t);
            gg += 10 * t;
        end
        else if (s < 24576)
        begin
            t = 4 * (s - 16384);
            gg += 10 * (cmsi_pkg::OneQ15 - t);
            rr += 10 * t;
        end
        else if (s < cmsi_pkg::OneQ15)
        begin
            rr += 10 * cmsi_pkg::OneQ15;
            gg += 40 * (s - 24576);
        end
        c.red = scale_default(rr);
        c.green = scale_default(gg);
        c.blue = scale_default(bb);
        c.src = cmsi_pkg::SRC_DEFAULT;
        return c;
    endfunction

    // Offer one word, wait for its acceptance, then update the predictor
    task automatic send_word(logic op, logic [2:0] idx, logic [15:0] pos,
                             cmsi_pkg::chan_t r, cmsi_pkg::chan_t g, cmsi_pkg::chan_t b,
                             logic [cmsi_pkg::SampW-1:0] samp);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, samp, b, g, r, pos, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == cmsi_pkg::OP_WRITE)
        begin
            stop_pos[idx] = (pos > cmsi_pkg::OneQ15) ? cmsi_pkg::PosW'(cmsi_pkg::OneQ15) : pos;
            stop_col[idx][0] = r;
            stop_col[idx][1] = g;
            stop_col[idx][2] = b;
            writes_sent++;
        end
        else
        begin
            color_queue.insert(color_queue.size(), predict_color(samp));
            lookups_sent++;
        end
        @(negedge clk);
    endtask

    task automatic send_lookup(logic [cmsi_pkg::SampW-1:0] samp);
        send_word(cmsi_pkg::OP_LOOKUP, 3'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), samp);
    endtask

    task automatic send_stop(int idx, logic [15:0] pos, cmsi_pkg::chan_t r,
                             cmsi_pkg::chan_t g, cmsi_pkg::chan_t b);
        send_word(cmsi_pkg::OP_WRITE, 3'(idx), pos, r, g, b, 17'($urandom));
    endtask

    // Drop valid and wait until the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (color_queue.size() != 0) @(posedge clk);
        repeat (cmsi_pkg::NumStages + 6) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == cmsi_pkg::REG_DISCRETE) mode_banded = value[0];
        else count_raw = value[3:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic banded, logic [3:0] cnt);
        drain();
        write_reg(cmsi_pkg::REG_DISCRETE, {31'($urandom), banded});
        write_reg(cmsi_pkg::REG_COUNT, {28'($urandom), cnt});
    endtask

    // Write eight stops in nondecreasing order with random colors
    task automatic load_sorted_table();
        int p;
        p = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4000);
        for (int i = 0; i < cmsi_pkg::MaxStops; i++)
        begin
            send_stop(i, 16'(p), 8'($urandom), 8'($urandom), 8'($urandom));
            case ($urandom_range(0, 5))
                0: p = p;
                1: p = p + 1;
                default: p = p + $urandom_range(0, 8000);
            endcase
            if (p > 40000) p = 40000;
        end
    endtask

    function automatic logic [cmsi_pkg::SampW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 17'($urandom);
            1: return 17'($signed(-$urandom_range(1, 65536)));
            2: return 17'($urandom_range(32769, 65535));
            3: return 17'(stop_pos[$urandom_range(0, cmsi_pkg::MaxStops - 1)]);
            4: return 17'(cmsi_pkg::OneQ15);
            default: return 17'($urandom_range(0, cmsi_pkg::OneQ15));
        endcase
    endfunction

    task automatic test_directed();
        // fill every entry first so no lookup ever reads an unwritten stop
        send_stop(0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_stop(1, 16'd32768, 8'd255, 8'd255, 8'd255);
        send_stop(2, 16'hFFFF, 8'd10, 8'd20, 8'd30);
        send_stop(3, 16'd32768, 8'd1, 8'd2, 8'd3);
        send_stop(4, 16'd32768, 8'd4, 8'd5, 8'd6);
        send_stop(5, 16'd32768, 8'd7, 8'd8, 8'd9);
        send_stop(6, 16'd32768, 8'd11, 8'd12, 8'd13);
        send_stop(7, 16'd32768, 8'd255, 8'd0, 8'd128);
        send_lookup(17'h10000);
        send_lookup(17'h1FFFF);
        send_lookup(17'd0);
        send_lookup(17'd16384);
        send_lookup(17'd32768);
        send_lookup(17'd32769);
        send_lookup(17'h0FFFF);
        // zero span and a gap with no bracketing pair
        send_stop(0, 16'd8000, 8'd50, 8'd60, 8'd70);
        send_stop(1, 16'd8000, 8'd90, 8'd80, 8'd70);
        send_lookup(17'd8000);
        send_lookup(17'd100);
        send_lookup(17'd20000);
        configure(1'b1, 4'd8);
        send_lookup(17'd8000);
        send_lookup(17'd32767);
        send_lookup(17'd30000);
        configure(1'b0, 4'd15);
        send_lookup(17'd32769);
        configure(1'b1, 4'd0);
        send_lookup(17'd32769);
        send_lookup(17'd4000);
    endtask

    // Send about the given number of words, writes included
    task automatic test_random(int items);
        int sent;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                load_sorted_table();
                sent += cmsi_pkg::MaxStops;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                send_stop($urandom_range(0, cmsi_pkg::MaxStops - 1), 16'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                send_lookup(pick_sample());
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) send_lookup(pick_sample());
        drain();
        for (int i = 0; i < 20; i++) send_lookup(pick_sample());
    endtask

    // Drive ready at the falling edge
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Compare each color word with the oldest prediction
    always @(posedge clk)
    begin
        color_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            colors_seen++;
            if (color_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color word %h src %0d", m_tdata, m_tuser);
            end
            else
            begin
                want = color_queue.pop_front();
                if (m_tdata[7:0] !== want.red || m_tdata[15:8] !== want.green ||
                    m_tdata[23:16] !== want.blue || m_tuser !== want.src)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"color mismatch: want r%0d g%0d b%0d src %0d, ",
                                  "got r%0d g%0d b%0d src %0d"},
                                 want.red, want.green, want.blue, want.src,
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
                end
            end
        end
    end

    initial
    begin
        #(12 * 3_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        mode_banded = 1'b0;
        count_raw = 4'd2;
        for (int i = 0; i < cmsi_pkg::MaxStops; i++)
        begin
            stop_pos[i] = '0;
            for (int c = 0; c < 3; c++) stop_col[i][c] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        send_idle = 8;
        recv_idle = 81;
        configure(1'b0, 4'd8);
        test_random(200);
        configure(1'b1, 4'd2);
        test_random(130);
        send_idle = 81;
        recv_idle = 8;
        configure(1'b0, 4'd5);
        test_random(200);
        configure(1'b1, 4'd7);
        test_random(130);
        send_idle = 0;
        recv_idle = 0;
        configure(1'b0, 4'd2);
        test_random(130);
        configure(1'b1, 4'd8);
        test_random(130);
        test_backpressure();
        drain();

        if (color_queue.size() != 0) mismatches++;
        $display("Sent %0d lookups and %0d stop writes, checked %0d color words,",
                 lookups_sent, writes_sent, colors_seen);
        $display("in both modes with odd stop counts, clamping, default map and long stalls.");
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
